// ----- rtl/irsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irsr_pkg
// Types and codes shared by the instance registry and service router.
// ----------------------------------------------------------------------------
package irsr_pkg;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_STOP  = 2'd1;
    localparam logic [1:0] CMD_MARK  = 2'd2;
    localparam logic [1:0] CMD_ROUTE = 2'd3;

    localparam logic [2:0] ST_STARTED  = 3'd0;
    localparam logic [2:0] ST_NO_FREE  = 3'd1;
    localparam logic [2:0] ST_CONFLICT = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_STOPPED  = 3'd4;
    localparam logic [2:0] ST_MARKED   = 3'd5;
    localparam logic [2:0] ST_ROUTED   = 3'd6;
    localparam logic [2:0] ST_NO_INST  = 3'd7;

    localparam logic [1:0] SLOT_FREE     = 2'd0;
    localparam logic [1:0] SLOT_STARTING = 2'd1;
    localparam logic [1:0] SLOT_RUNNING  = 2'd2;

    localparam int HASH_W = 32;

    typedef struct packed {
        logic [1:0]        command;
        logic              has_requested_id;
        logic [7:0]        inst_id;
        logic [3:0]        svc_id;
        logic [HASH_W-1:0] flow_hash;
    } cmd_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_id;
    } rsp_item_t;

endpackage

// ----- rtl/instance_registry_and_service_router_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instance_registry_and_service_router_top
// Instance slot registry with per-service member lists and hash routing.
// ----------------------------------------------------------------------------
// One item at a time. All state sits in synchronous memories (slot states,
// member counts, member lists) read through registered outputs; slot states
// and counts carry reset-cleared valid bits, so no clearing pass is needed.
// Per item: start first advances the next-free pointer past running slots,
// then reads the slot and the count; stop clears the slot, reads the count and
// scans the service list, moving later entries down; mark reads the slot;
// route reads the count, runs the bit-serial hash-modulo-count divider and
// then reads the list. Each result is loaded into the output register and the
// block returns to idle, where the next item is accepted. A finished result
// waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module instance_registry_and_service_router_top #(
    parameter int MAX_INSTANCES   = 16,
    parameter int MAX_PER_SERVICE = 8,
    parameter int NUM_SERVICES    = 16
) (
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  irsr_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output irsr_pkg::rsp_item_t rsp,
    input  logic                clk,
    input  logic                rst_n
);
    import irsr_pkg::*;

    localparam int IW   = (MAX_INSTANCES > 2) ? $clog2(MAX_INSTANCES) : 1;
    localparam int NFW  = $clog2(MAX_INSTANCES + 1);
    localparam int SW   = (NUM_SERVICES > 1) ? $clog2(NUM_SERVICES) : 1;
    localparam int SXW  = (SW > 4) ? SW : 4;
    localparam int KW   = (MAX_PER_SERVICE > 1) ? $clog2(MAX_PER_SERVICE) : 1;
    localparam int CW   = $clog2(MAX_PER_SERVICE + 1);
    localparam int MW   = SW + KW;
    localparam int MDEP = NUM_SERVICES << KW;
    localparam int BCW  = $clog2(HASH_W + 1);

    typedef enum logic [16:0] {
        S_IDLE       = 17'h00001,
        S_SKIP_RD    = 17'h00002,
        S_SKIP_CHK   = 17'h00004,
        S_ID         = 17'h00008,
        S_ID_CHK     = 17'h00010,
        S_STOP       = 17'h00020,
        S_STOP_CNT   = 17'h00040,
        S_SCAN_RD    = 17'h00080,
        S_SCAN_CHK   = 17'h00100,
        S_MARK       = 17'h00200,
        S_MARK_CHK   = 17'h00400,
        S_ROUTE      = 17'h00800,
        S_ROUTE_CNT  = 17'h01000,
        S_DIV        = 17'h02000,
        S_ROUTE_RD   = 17'h04000,
        S_ROUTE_DATA = 17'h08000,
        S_DONE       = 17'h10000
    } state_t;

    // Memories: slot state, member count, member list
    logic [1:0]    slot_mem [MAX_INSTANCES];
    logic [CW-1:0] cnt_mem  [NUM_SERVICES];
    logic [IW-1:0] mbr_mem  [MDEP];

    logic [MAX_INSTANCES-1:0] slot_vld_reg;
    logic [NUM_SERVICES-1:0]  cnt_vld_reg;

    state_t         state_reg, state_next;
    cmd_item_t      item_reg;
    logic [NFW-1:0] nf_reg, nf_next;
    logic [IW-1:0]  id_reg, id_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  k_reg, k_next;
    logic           found_reg, found_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [BCW-1:0] bit_reg, bit_next;
    rsp_item_t      res_reg, res_next;
    rsp_item_t      rsp_reg;
    logic           rsp_valid_reg;

    // Memory ports
    logic          slot_re, slot_we;
    logic [IW-1:0] slot_raddr, slot_waddr;
    logic [1:0]    slot_wdata;
    logic [1:0]    slot_rdata_reg;
    logic          slot_rvld_reg;
    logic          cnt_re, cnt_we;
    logic [CW-1:0] cnt_wdata;
    logic [CW-1:0] cnt_rdata_reg;
    logic          cnt_rvld_reg;
    logic          mbr_re, mbr_we;
    logic [MW-1:0] mbr_raddr, mbr_waddr;
    logic [IW-1:0] mbr_wdata;
    logic [IW-1:0] mbr_rdata_reg;

    // Decoded fields of the held item
    logic [SXW-1:0] svc_ext;
    logic [SW-1:0]  svc_idx;
    logic           svc_ok;
    logic           id_ok;
    logic [IW-1:0]  id_idx;
    logic [8:0]     start_id;
    logic [1:0]     slot_rd;
    logic [CW-1:0]  cnt_rd;
    logic [CW:0]    div_trial;
    logic           out_free;

    assign svc_ext  = SXW'(item_reg.svc_id);
    assign svc_idx  = svc_ext[SW-1:0];
    assign svc_ok   = {1'b0, svc_ext} < (SXW + 1)'(NUM_SERVICES);
    assign id_ok    = {1'b0, item_reg.inst_id} < 9'(MAX_INSTANCES);
    assign id_idx   = IW'(item_reg.inst_id);
    assign start_id = item_reg.has_requested_id ? {1'b0, item_reg.inst_id}
                                                : 9'(nf_reg);
    // Unwritten entries read as their reset value
    assign slot_rd   = slot_rvld_reg ? slot_rdata_reg : SLOT_FREE;
    assign cnt_rd    = cnt_rvld_reg ? cnt_rdata_reg : '0;
    assign div_trial = {rem_reg, hash_reg[HASH_W-1]};
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        nf_next    = nf_reg;
        id_next    = id_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        found_next = found_reg;
        rem_next   = rem_reg;
        hash_next  = hash_reg;
        bit_next   = bit_reg;
        res_next   = res_reg;
        slot_re    = 1'b0;
        slot_raddr = id_idx;
        slot_we    = 1'b0;
        slot_waddr = id_idx;
        slot_wdata = SLOT_FREE;
        cnt_re     = 1'b0;
        cnt_we     = 1'b0;
        cnt_wdata  = '0;
        mbr_re     = 1'b0;
        mbr_raddr  = {svc_idx, k_reg[KW-1:0]};
        mbr_we     = 1'b0;
        mbr_waddr  = {svc_idx, KW'(k_reg - 1'b1)};
        mbr_wdata  = mbr_rdata_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.command)
                        CMD_START: state_next = S_SKIP_RD;
                        CMD_STOP:  state_next = S_STOP;
                        CMD_MARK:  state_next = S_MARK;
                        default:   state_next = S_ROUTE;
                    endcase
                end
            end
            S_SKIP_RD:
            begin
                // advance the pointer past running slots, one read per slot
                if (nf_reg < NFW'(MAX_INSTANCES))
                begin
                    slot_re    = 1'b1;
                    slot_raddr = IW'(nf_reg);
                    state_next = S_SKIP_CHK;
                end
                else
                begin
                    state_next = S_ID;
                end
            end
            S_SKIP_CHK:
            begin
                if (slot_rd == SLOT_RUNNING)
                begin
                    nf_next    = nf_reg + 1'b1;
                    state_next = S_SKIP_RD;
                end
                else
                begin
                    state_next = S_ID;
                end
            end
            S_ID:
            begin
                if (!item_reg.has_requested_id && nf_reg < NFW'(MAX_INSTANCES))
                begin
                    nf_next = nf_reg + 1'b1;
                end
                id_next = IW'(start_id);
                if (start_id >= 9'(MAX_INSTANCES))
                begin
                    res_next   = '{status: ST_NO_FREE, result_id: 4'd0};
                    state_next = S_DONE;
                end
                else
                begin
                    slot_re    = 1'b1;
                    slot_raddr = IW'(start_id);
                    cnt_re     = 1'b1;
                    state_next = S_ID_CHK;
                end
            end
            S_ID_CHK:
            begin
                state_next = S_DONE;
                if (slot_rd == SLOT_RUNNING)
                begin
                    res_next = '{status: ST_CONFLICT, result_id: 4'd0};
                end
                else if (!svc_ok || cnt_rd >= CW'(MAX_PER_SERVICE))
                begin
                    res_next = '{status: ST_FULL, result_id: 4'd0};
                end
                else
                begin
                    slot_we    = 1'b1;
                    slot_waddr = id_reg;
                    slot_wdata = SLOT_STARTING;
                    mbr_we     = 1'b1;
                    mbr_waddr  = {svc_idx, cnt_rd[KW-1:0]};
                    mbr_wdata  = id_reg;
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_rd + 1'b1;
                    res_next   = '{status: ST_STARTED,
                                   result_id: 4'(9'(id_reg))};
                end
            end
            S_STOP:
            begin
                slot_we    = id_ok;
                slot_wdata = SLOT_FREE;
                res_next   = '{status: ST_STOPPED, result_id: 4'd0};
                if (svc_ok)
                begin
                    cnt_re     = 1'b1;
                    state_next = S_STOP_CNT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_STOP_CNT:
            begin
                cnt_next   = cnt_rd;
                k_next     = '0;
                found_next = 1'b0;
                if (cnt_rd != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = cnt_rd - 1'b1;
                end
                state_next = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (k_reg < cnt_reg)
                begin
                    mbr_re     = 1'b1;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SCAN_CHK:
            begin
                // after the match, move every later entry down by one
                if (found_reg)
                begin
                    mbr_we = 1'b1;
                end
                else if (9'(mbr_rdata_reg) == {1'b0, item_reg.inst_id})
                begin
                    found_next = 1'b1;
                end
                k_next     = k_reg + 1'b1;
                state_next = S_SCAN_RD;
            end
            S_MARK:
            begin
                res_next = '{status: ST_MARKED, result_id: 4'd0};
                if (id_ok)
                begin
                    slot_re    = 1'b1;
                    state_next = S_MARK_CHK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK_CHK:
            begin
                if (slot_rd == SLOT_STARTING)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = SLOT_RUNNING;
                end
                state_next = S_DONE;
            end
            S_ROUTE:
            begin
                res_next = '{status: ST_NO_INST, result_id: 4'd0};
                if (svc_ok)
                begin
                    cnt_re     = 1'b1;
                    state_next = S_ROUTE_CNT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROUTE_CNT:
            begin
                cnt_next  = cnt_rd;
                rem_next  = '0;
                hash_next = item_reg.flow_hash;
                bit_next  = '0;
                if (cnt_rd == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                // restoring division, one hash bit per cycle
                if (div_trial >= {1'b0, cnt_reg})
                begin
                    rem_next = CW'(div_trial - {1'b0, cnt_reg});
                end
                else
                begin
                    rem_next = CW'(div_trial);
                end
                hash_next = {hash_reg[HASH_W-2:0], 1'b0};
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == BCW'(HASH_W - 1))
                begin
                    state_next = S_ROUTE_RD;
                end
            end
            S_ROUTE_RD:
            begin
                mbr_re     = 1'b1;
                mbr_raddr  = {svc_idx, rem_reg[KW-1:0]};
                state_next = S_ROUTE_DATA;
            end
            S_ROUTE_DATA:
            begin
                res_next   = '{status: ST_ROUTED,
                               result_id: 4'(9'(mbr_rdata_reg))};
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nf_reg        <= NFW'(1);
            rsp_valid_reg <= 1'b0;
            slot_vld_reg  <= '0;
            cnt_vld_reg   <= '0;
            found_reg     <= 1'b0;
            bit_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            nf_reg    <= nf_next;
            found_reg <= found_next;
            bit_reg   <= bit_next;
            if (slot_we)
            begin
                slot_vld_reg[slot_waddr] <= 1'b1;
            end
            if (cnt_we)
            begin
                cnt_vld_reg[svc_idx] <= 1'b1;
            end
            if (state_reg == S_DONE && out_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            item_reg <= cmd;
        end
        id_reg   <= id_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        rem_reg  <= rem_next;
        hash_reg <= hash_next;
        res_reg  <= res_next;
        if (state_reg == S_DONE && out_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    // Slot state memory
    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re)
        begin
            slot_rdata_reg <= slot_mem[slot_raddr];
            slot_rvld_reg  <= slot_vld_reg[slot_raddr];
        end
    end

    // Member count memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[svc_idx] <= cnt_wdata;
        end
        if (cnt_re)
        begin
            cnt_rdata_reg <= cnt_mem[svc_idx];
            cnt_rvld_reg  <= cnt_vld_reg[svc_idx];
        end
    end

    // Member list memory
    always_ff @(posedge clk)
    begin
        if (mbr_we)
        begin
            mbr_mem[mbr_waddr] <= mbr_wdata;
        end
        if (mbr_re)
        begin
            mbr_rdata_reg <= mbr_mem[mbr_raddr];
        end
    end

    // Checks
    a_nf_range: assert property (@(posedge clk) disable iff (!rst_n)
        nf_reg != '0 && nf_reg <= NFW'(MAX_INSTANCES))
        else $error("next-free pointer out of range");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> state_reg != S_IDLE)
        else $error("accepted item did not start work");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> rsp_valid)
        else $error("finished item not presented");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN_CHK |-> k_reg < cnt_reg)
        else $error("list scan beyond member count");

endmodule

// ----- tb/tb_instance_registry_and_service_router_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_instance_registry_and_service_router_top
// Self-checking bench for the instance registry and service router.
// ----------------------------------------------------------------------------
// A directed table of commands runs first. It covers the reset state, the
// extremes of the fields and the corner cases. Random traffic follows. It is
// mostly start, mark, route and stop of live instances, with some noise.
// Every accepted command is predicted by a behavioral copy of the registry.
// Responses are checked in order against that prediction. Gaps of random
// length are placed on both channels.
// ----------------------------------------------------------------------------
module tb_instance_registry_and_service_router_top;
    import irsr_pkg::*;

    localparam int N_INST  = 16;
    localparam int N_MEM   = 8;
    localparam int N_SVC   = 16;
    localparam int N_RAND  = 1930;
    localparam int LIMIT   = 3000000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_stall;
    cmd_item_t cmd;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    instance_registry_and_service_router_top u_dut (
        .cmd_valid(cmd_valid),
        .cmd_stall(cmd_stall),
        .cmd      (cmd),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .clk      (clk),
        .rst_n    (rst_n)
    );

    // Predictor state: a private copy of the registry.
    logic [1:0] slot_q [N_INST];
    int         next_free_q;
    int         count_q [N_SVC];
    logic [7:0] members_q [N_SVC][N_MEM];

    rsp_item_t  pending_rsp [$];
    int         errors;
    int         checked;
    int         cycles;

    // One directed row: the command, whether the response is typed in here,
    // and that response.
    typedef struct {
        cmd_item_t c;
        bit        fixed;
        rsp_item_t r;
    } dir_row_t;

    function automatic cmd_item_t make_cmd(logic [1:0] op, logic req, logic [7:0] id,
                                           logic [3:0] svc, logic [31:0] h);
        cmd_item_t c;
        c.command          = op;
        c.has_requested_id = req;
        c.inst_id          = id;
        c.svc_id           = svc;
        c.flow_hash        = h;
        return c;
    endfunction

    function automatic rsp_item_t make_rsp(logic [2:0] st, logic [3:0] id);
        rsp_item_t r;
        r.status    = st;
        r.result_id = id;
        return r;
    endfunction

    // Work out the response of one command and advance the predictor state.
    function automatic rsp_item_t registry_step(cmd_item_t c);
        rsp_item_t r;
        int        id;
        int        svc;
        int        cnt;
        int        k;
        r   = make_rsp(ST_STARTED, 4'd0);
        id  = c.inst_id;
        svc = c.svc_id;
        case (c.command)
            CMD_START:
            begin
                while (next_free_q < N_INST && slot_q[next_free_q] == SLOT_RUNNING)
                    next_free_q++;
                if (!c.has_requested_id)
                begin
                    id = next_free_q;
                    if (next_free_q < N_INST)
                        next_free_q++;
                end
                if (id >= N_INST)
                    r.status = ST_NO_FREE;
                else if (slot_q[id] == SLOT_RUNNING)
                    r.status = ST_CONFLICT;
                else if (svc >= N_SVC || count_q[svc] >= N_MEM)
                    r.status = ST_FULL;
                else
                begin
                    slot_q[id] = SLOT_STARTING;
                    members_q[svc][count_q[svc]] = id[7:0];
                    count_q[svc]++;
                    r.result_id = id[3:0];
                end
            end
            CMD_STOP:
            begin
                r.status = ST_STOPPED;
                if (id < N_INST)
                    slot_q[id] = SLOT_FREE;
                if (svc < N_SVC)
                begin
                    cnt = count_q[svc];
                    k = 0;
                    while (k < cnt && members_q[svc][k] != id[7:0])
                        k++;
                    if (k < cnt)
                    begin
                        for (; k + 1 < cnt; k++)
                            members_q[svc][k] = members_q[svc][k + 1];
                    end
                    if (count_q[svc] > 0)
                        count_q[svc]--;
                end
            end
            CMD_MARK:
            begin
                r.status = ST_MARKED;
                if (id < N_INST && slot_q[id] == SLOT_STARTING)
                    slot_q[id] = SLOT_RUNNING;
            end
            default:
            begin
                if (svc >= N_SVC || count_q[svc] == 0)
                    r.status = ST_NO_INST;
                else
                begin
                    r.status    = ST_ROUTED;
                    r.result_id = members_q[svc][c.flow_hash % count_q[svc]][3:0];
                end
            end
        endcase
        return r;
    endfunction

    // Gap length for either channel: mostly short, a few long.
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random command. Most of them keep the list sequence valid, with a few
    // stray ids, unknown services and odd field values mixed in.
    function automatic cmd_item_t random_cmd();
        cmd_item_t c;
        int        p;
        int        svc;
        c = cmd_item_t'($bits(cmd_item_t)'({$urandom, $urandom}));
        p = $urandom_range(0, 99);
        svc = $urandom_range(0, 3);
        c.svc_id = svc[3:0];
        if (p < 30)
        begin
            c.command = CMD_START;
            if (c.has_requested_id && $urandom_range(0, 3) != 0)
                c.inst_id = 8'($urandom_range(0, N_INST - 1));
        end
        else if (p < 50)
        begin
            c.command = CMD_MARK;
            if ($urandom_range(0, 7) != 0)
                c.inst_id = 8'($urandom_range(0, N_INST - 1));
        end
        else if (p < 75)
        begin
            c.command = CMD_ROUTE;
        end
        else if (p < 97)
        begin
            // Stop a real member most of the time, to keep the lists churning.
            c.command = CMD_STOP;
            if (count_q[svc] > 0 && $urandom_range(0, 4) != 0)
                c.inst_id = members_q[svc][$urandom_range(0, count_q[svc] - 1)];
            else if ($urandom_range(0, 1))
                c.inst_id = 8'($urandom_range(0, N_INST - 1));
        end
        if ($urandom_range(0, 9) == 0)
            c.svc_id = 4'($urandom);
        return c;
    endfunction

    dir_row_t dir_table [$];

    // Hold back the next command for a gap, then present it and wait until
    // it is accepted.
    task automatic send_cmd(cmd_item_t c);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
    endtask

    // Predict when the command is issued, before it is presented. Only one item is in flight.
    task automatic issue(cmd_item_t c);
        pending_rsp.push_back(registry_step(c));
        send_cmd(c);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Response side: stall at random and check each accepted item.
    initial
    begin
        int        g;
        rsp_item_t want;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            if (g > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (g) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
            if (pending_rsp.size() == 0)
            begin
                $error("response with nothing expected: status %0d id %0d",
                       rsp.status, rsp.result_id);
                errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                checked++;
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    errors++;
                end
                if (rsp.result_id !== want.result_id)
                begin
                    $error("result_id: expected %0d, got %0d", want.result_id,
                           rsp.result_id);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t  row;
        rsp_item_t got;
        errors    = 0;
        checked   = 0;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        for (int i = 0; i < N_INST; i++)
            slot_q[i] = SLOT_FREE;
        for (int s = 0; s < N_SVC; s++)
            count_q[s] = 0;
        next_free_q = 1;

        // After reset: empty service, then the first allocated id is 1.
        dir_table.push_back('{make_cmd(CMD_ROUTE, 0, 0, 0, 32'hFFFF_FFFF), 1,
                              make_rsp(ST_NO_INST, 0)});
        dir_table.push_back('{make_cmd(CMD_START, 0, 8'hFF, 0, 0), 1,
                              make_rsp(ST_STARTED, 1)});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'hFF, 0, 0), 1,
                              make_rsp(ST_NO_FREE, 0)});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'd16, 1, 0), 1,
                              make_rsp(ST_NO_FREE, 0)});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'd15, 4'hF, 0), 1,
                              make_rsp(ST_STARTED, 15)});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'd15, 4'hF, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'd0, 0, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_MARK, 0, 8'd1, 0, 0), 1,
                              make_rsp(ST_MARKED, 0)});
        dir_table.push_back('{make_cmd(CMD_START, 1, 8'd1, 2, 0), 1,
                              make_rsp(ST_CONFLICT, 0)});
        dir_table.push_back('{make_cmd(CMD_MARK, 1, 8'd1, 0, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_MARK, 0, 8'hFF, 0, 0), 1,
                              make_rsp(ST_MARKED, 0)});
        dir_table.push_back('{make_cmd(CMD_ROUTE, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
        dir_table.push_back('{make_cmd(CMD_ROUTE, 1, 8'hFF, 4'hF, 32'h0), 0, '0});
        // Fill service 3 to the limit, then overflow it with an allocated id.
        for (int i = 0; i < N_MEM; i++)
            dir_table.push_back('{make_cmd(CMD_START, 0, 0, 3, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_START, 0, 0, 3, 0), 1,
                              make_rsp(ST_FULL, 0)});
        dir_table.push_back('{make_cmd(CMD_ROUTE, 0, 0, 3, 32'h8000_0007), 0, '0});
        dir_table.push_back('{make_cmd(CMD_STOP, 0, 8'd4, 3, 0), 1,
                              make_rsp(ST_STOPPED, 0)});
        dir_table.push_back('{make_cmd(CMD_STOP, 0, 8'hFF, 3, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_STOP, 0, 8'd9, 4'd9, 0), 0, '0});
        dir_table.push_back('{make_cmd(CMD_ROUTE, 0, 0, 3, 32'h0000_0005), 0, '0});

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the table. A typed-in response must agree with the predictor.
        foreach (dir_table[i])
        begin
            row = dir_table[i];
            got = registry_step(row.c);
            if (row.fixed && got != row.r)
            begin
                $error("directed row %0d: table expects status %0d id %0d", i,
                       row.r.status, row.r.result_id);
                errors++;
            end
            pending_rsp.push_back(row.fixed ? row.r : got);
            send_cmd(row.c);
        end

        for (int i = 0; i < N_RAND; i++)
            issue(random_cmd());
        cmd_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("Checked %0d responses over %0d commands: directed table and random traffic.",
                 checked, dir_table.size() + N_RAND);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
